@@ sv/bia_pkg.sv @@
// ----------------------------------------------------------------------------
// bia_pkg: shared types and codes for the bitmap index allocator
// Command and status codes, the transaction payload structs and the
// controller state type.
// ----------------------------------------------------------------------------
`default_nettype none

package bia_pkg;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_FULL      = 2'd1;
  localparam logic [1:0] STATUS_NOT_ALLOC = 2'd2;

  typedef struct packed {
    logic       cmd;
    logic [7:0] slot_index;
  } in_t;

  typedef struct packed {
    logic [7:0] given_index;
    logic [1:0] status;
    logic [8:0] live_total;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MARK_RD,
    ST_MARK_WR,
    ST_FREE_RD,
    ST_FREE_CHK,
    ST_RESP
  } state_e;

endpackage

`default_nettype wire

@@ sv/bitmap_index_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// bitmap_index_allocator_unit: allocator of small integer indices
// Keeps an in-use bitmap in a byte-wide memory, a high-water mark and a
// live count. Allocation reuses a hole below the mark, found by scanning
// the bitmap one byte per cycle from the top, or else takes the mark.
// ----------------------------------------------------------------------------
//
//   Channel | Signals                        | Payload
//   --------+--------------------------------+---------------------
//   input   | in_valid_i / in_stall_o        | bia_pkg::in_t
//   output  | out_valid_o / out_stall_i      | bia_pkg::out_t
//
// One transaction is handled at a time; in_stall_o is high while it is busy.
// Allocate with a hole: one memory byte read per cycle while scanning down
// from the top byte. Allocate at the mark and free each step through a
// registered memory read, a write or check, and a response state.
// Bitmap bytes at or above the mark are treated as empty and rewritten when
// the mark enters them, so reset and the last free need no clearing pass.
// A stalled result holds in the output register until it is taken.
`default_nettype none

module bitmap_index_allocator_unit #(
  parameter int CAPACITY = 256
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire bia_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output bia_pkg::out_t      out_data_o
);

  localparam int MapBytes = (CAPACITY + 7) / 8;
  localparam int AW       = (MapBytes > 1) ? $clog2(MapBytes) : 1;
  localparam int HwW      = $clog2(CAPACITY + 1);
  localparam int CW       = (HwW > 8) ? HwW : 8;
  localparam logic [HwW-1:0] CapHw = HwW'(CAPACITY);
  localparam logic [CW-1:0]  CapC  = CW'(CAPACITY);

  bia_pkg::state_e state_q, state_d;

  logic [7:0]       idx_q, idx_d;
  logic [HwW-1:0]   hw_q, hw_d;
  logic [HwW-1:0]   live_q, live_d;
  logic [AW-1:0]    scan_q, scan_d;
  logic             issue_v_q, issue_v_d;
  logic [AW-1:0]    chk_b_q, chk_b_d;
  logic             chk_v_q, chk_v_d;
  bia_pkg::out_t    res_q, res_d;
  bia_pkg::out_t    out_q, out_d;
  logic             out_valid_q, out_valid_d;

  logic [7:0]       mem [MapBytes];
  logic [7:0]       rd_data_q;
  logic [AW-1:0]    rd_addr;
  logic             wr_en;
  logic [AW-1:0]    wr_addr;
  logic [7:0]       wr_data;

  logic             in_accept;
  logic             can_mark;
  logic [AW+HwW-1:0] hw_byte_w;
  logic [AW-1:0]    hw_byte;
  logic             hw_part;
  logic [AW+4:0]    idx_byte_w;
  logic [AW-1:0]    idx_byte;
  logic [HwW:0]     top_w;
  logic [7:0]       masked;
  logic             found;
  logic [2:0]       zero_bit;
  logic [AW+10:0]   got_w;
  logic [HwW+8:0]   hw_w;
  logic [HwW-1:0]   live_inc;
  logic [HwW-1:0]   live_dec;
  logic [HwW+8:0]   live_inc_w;
  logic [HwW+8:0]   live_dec_w;
  logic [HwW+8:0]   live_cur_w;
  logic [CW-1:0]    idx_c;
  logic [CW-1:0]    hw_c;
  logic             free_ok;

  assign in_accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != bia_pkg::ST_IDLE);
  assign can_mark = (hw_q < CapHw);

  assign hw_byte_w  = (AW + HwW)'(hw_q[HwW-1:3]);
  assign hw_byte    = hw_byte_w[AW-1:0];
  assign hw_part    = (hw_q[2:0] != 3'd0);
  assign idx_byte_w = (AW + 5)'(idx_q[7:3]);
  assign idx_byte   = idx_byte_w[AW-1:0];
  assign top_w      = (({1'b0, hw_q} + (HwW + 1)'(7)) >> 3) - (HwW + 1)'(1);

  // Bits at or above the mark only exist in the partially used top byte.
  assign masked = rd_data_q |
                  ((hw_part && (chk_b_q == hw_byte)) ? (8'hff << hw_q[2:0]) : 8'h00);
  assign found  = chk_v_q && (masked != 8'hff);

  always_comb begin
    zero_bit = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if (!masked[i]) begin
        zero_bit = 3'(i);
      end
    end
  end

  assign got_w      = (AW + 11)'({chk_b_q, zero_bit});
  assign hw_w       = (HwW + 9)'(hw_q);
  assign live_inc   = live_q + HwW'(1);
  assign live_dec   = (live_q != '0) ? (live_q - HwW'(1)) : live_q;
  assign live_inc_w = (HwW + 9)'(live_inc);
  assign live_dec_w = (HwW + 9)'(live_dec);
  assign live_cur_w = (HwW + 9)'(live_q);
  assign idx_c      = CW'(idx_q);
  assign hw_c       = CW'(hw_q);
  assign free_ok    = (idx_c < hw_c) && (idx_c < CapC) && rd_data_q[idx_q[2:0]];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bia_pkg::ST_IDLE: begin
        if (in_accept) begin
          if (in_data_i.cmd == bia_pkg::CMD_FREE) begin
            state_d = bia_pkg::ST_FREE_RD;
          end else if (hw_q != live_q) begin
            state_d = bia_pkg::ST_SCAN;
          end else if (can_mark) begin
            state_d = bia_pkg::ST_MARK_RD;
          end else begin
            state_d = bia_pkg::ST_RESP;
          end
        end
      end
      bia_pkg::ST_SCAN: begin
        if (found) begin
          state_d = bia_pkg::ST_RESP;
        end else if (chk_v_q && !issue_v_q) begin
          state_d = can_mark ? bia_pkg::ST_MARK_RD : bia_pkg::ST_RESP;
        end
      end
      bia_pkg::ST_MARK_RD:  state_d = bia_pkg::ST_MARK_WR;
      bia_pkg::ST_MARK_WR:  state_d = bia_pkg::ST_RESP;
      bia_pkg::ST_FREE_RD:  state_d = bia_pkg::ST_FREE_CHK;
      bia_pkg::ST_FREE_CHK: state_d = bia_pkg::ST_RESP;
      bia_pkg::ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          state_d = bia_pkg::ST_IDLE;
        end
      end
      default: state_d = bia_pkg::ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    idx_d       = idx_q;
    hw_d        = hw_q;
    live_d      = live_q;
    scan_d      = scan_q;
    issue_v_d   = issue_v_q;
    chk_b_d     = chk_b_q;
    chk_v_d     = 1'b0;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    rd_addr     = scan_q;
    wr_en       = 1'b0;
    wr_addr     = chk_b_q;
    wr_data     = rd_data_q;

    unique case (state_q)
      bia_pkg::ST_IDLE: begin
        if (in_accept) begin
          idx_d             = in_data_i.slot_index;
          scan_d            = top_w[AW-1:0];
          issue_v_d         = 1'b1;
          res_d.given_index = 8'd0;
          res_d.status      = bia_pkg::STATUS_FULL;
          res_d.live_total  = live_cur_w[8:0];
        end
      end
      bia_pkg::ST_SCAN: begin
        // Read one byte per cycle; the byte read last cycle is checked now.
        rd_addr = scan_q;
        chk_b_d = scan_q;
        chk_v_d = issue_v_q;
        if (issue_v_q) begin
          if (scan_q == '0) begin
            issue_v_d = 1'b0;
          end else begin
            scan_d = scan_q - AW'(1);
          end
        end
        if (found) begin
          wr_en             = 1'b1;
          wr_addr           = chk_b_q;
          wr_data           = rd_data_q | (8'h01 << zero_bit);
          live_d            = live_inc;
          res_d.given_index = got_w[7:0];
          res_d.status      = bia_pkg::STATUS_OK;
          res_d.live_total  = live_inc_w[8:0];
        end
      end
      bia_pkg::ST_MARK_RD: begin
        rd_addr = hw_byte;
      end
      bia_pkg::ST_MARK_WR: begin
        // A byte entered at its first bit holds stale data and is rewritten.
        wr_en             = 1'b1;
        wr_addr           = hw_byte;
        wr_data           = hw_part ? (rd_data_q | (8'h01 << hw_q[2:0])) : 8'h01;
        hw_d              = hw_q + HwW'(1);
        live_d            = live_inc;
        res_d.given_index = hw_w[7:0];
        res_d.status      = bia_pkg::STATUS_OK;
        res_d.live_total  = live_inc_w[8:0];
      end
      bia_pkg::ST_FREE_RD: begin
        rd_addr = idx_byte;
      end
      bia_pkg::ST_FREE_CHK: begin
        res_d.given_index = 8'd0;
        if (free_ok) begin
          wr_en            = 1'b1;
          wr_addr          = idx_byte;
          wr_data          = rd_data_q & ~(8'h01 << idx_q[2:0]);
          live_d           = live_dec;
          if (live_dec == '0) begin
            hw_d = '0;
          end
          res_d.status     = bia_pkg::STATUS_OK;
          res_d.live_total = live_dec_w[8:0];
        end else begin
          res_d.status     = bia_pkg::STATUS_NOT_ALLOC;
          res_d.live_total = live_cur_w[8:0];
        end
      end
      bia_pkg::ST_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        chk_v_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bia_pkg::ST_IDLE;
      hw_q        <= '0;
      live_q      <= '0;
      issue_v_q   <= 1'b0;
      chk_v_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hw_q        <= hw_d;
      live_q      <= live_d;
      issue_v_q   <= issue_v_d;
      chk_v_q     <= chk_v_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q   <= idx_d;
    scan_q  <= scan_d;
    chk_b_q <= chk_b_d;
    res_q   <= res_d;
    out_q   <= out_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_q <= mem[rd_addr];
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

@@ tb/tb_bitmap_index_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bitmap_index_allocator_unit: self-checking bench for the index allocator
// Drives allocate and free commands, predicts every response from a local
// copy of the bitmap, mark and live count, and checks each response field by
// field. Runs fill, mixed and drain sequences under three idle patterns.
// ----------------------------------------------------------------------------

class alloc_scoreboard #(int SLOTS = 256);
  logic [SLOTS-1:0] in_use;
  int unsigned      mark;
  int unsigned      live;
  bia_pkg::out_t    awaited[$];

  function new();
    in_use = '0;
    mark   = 0;
    live   = 0;
  endfunction

  function int unsigned pending();
    return awaited.size();
  endfunction

  // Highest byte below the mark with a free bit, lowest free bit in it.
  function bit find_hole(output int unsigned slot);
    logic [7:0]  bits;
    int unsigned k;
    slot = 0;
    for (int b = (int'(mark) + 7) / 8 - 1; b >= 0; b--) begin
      bits = in_use[b*8 +: 8];
      for (int i = 0; i < 8; i++) begin
        if (b * 8 + i >= mark) bits[i] = 1'b1;
      end
      if (bits != 8'hff) begin
        k = 0;
        while (k < 7 && bits[k]) k++;
        slot = b * 8 + k;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Random index that is currently in use; any index when none is.
  function logic [7:0] pick_live();
    int unsigned k;
    if (live == 0) return 8'($urandom_range(255));
    k = $urandom_range(live - 1);
    for (int i = 0; i < SLOTS; i++) begin
      if (in_use[i]) begin
        if (k == 0) return 8'(i);
        k--;
      end
    end
    return 8'd0;
  endfunction

  function bia_pkg::out_t note_command(bia_pkg::in_t item);
    bia_pkg::out_t resp;
    int unsigned   slot;
    resp = '0;
    resp.status = bia_pkg::STATUS_OK;
    if (item.cmd == bia_pkg::CMD_ALLOC) begin
      if (mark != live && find_hole(slot)) begin
        in_use[slot] = 1'b1;
        live++;
        resp.given_index = 8'(slot);
      end else if (mark < SLOTS) begin
        in_use[mark] = 1'b1;
        resp.given_index = 8'(mark);
        mark++;
        live++;
      end else begin
        resp.status = bia_pkg::STATUS_FULL;
      end
    end else if (item.slot_index >= mark || !in_use[item.slot_index]) begin
      resp.status = bia_pkg::STATUS_NOT_ALLOC;
    end else begin
      in_use[item.slot_index] = 1'b0;
      if (live > 0) live--;
      if (live == 0) begin
        in_use = '0;
        mark   = 0;
      end
    end
    resp.live_total = 9'(live);
    awaited.push_back(resp);
    return resp;
  endfunction

  function void check_response(input bia_pkg::out_t got, output string faults[$]);
    bia_pkg::out_t want;
    faults = {};
    if (awaited.size() == 0) begin
      faults.push_back($sformatf("response with no command outstanding: %p", got));
      return;
    end
    want = awaited.pop_front();
    if (got.given_index !== want.given_index)
      faults.push_back($sformatf("given_index got %0d want %0d",
                                 got.given_index, want.given_index));
    if (got.status !== want.status)
      faults.push_back($sformatf("status got %0d want %0d", got.status, want.status));
    if (got.live_total !== want.live_total)
      faults.push_back($sformatf("live_total got %0d want %0d",
                                 got.live_total, want.live_total));
  endfunction
endclass

module tb_bitmap_index_allocator_unit;

  localparam int SLOTS = 256;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid;
  logic          in_stall;
  bia_pkg::in_t  in_data;
  logic          out_valid;
  logic          out_stall;
  bia_pkg::out_t out_data;

  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned errors;
  int unsigned full_hits;

  alloc_scoreboard #(SLOTS) sb;

  bitmap_index_allocator_unit #(
    .CAPACITY(SLOTS)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH at %0t ns: %s", $time, what);
  endtask

  // Each transaction is predicted at the edge where it is accepted, so the
  // next free target is chosen from the state after every accepted command.
  task automatic send_command(input logic cmd, input logic [7:0] slot);
    bia_pkg::in_t  item;
    bia_pkg::out_t pred;
    item.cmd        = cmd;
    item.slot_index = slot;
    while ($urandom_range(99) < send_idle) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk_i); while (in_stall);
    pred = sb.note_command(item);
    if (pred.status == bia_pkg::STATUS_FULL) full_hits++;
  endtask

  task automatic send_alloc();
    send_command(bia_pkg::CMD_ALLOC, 8'($urandom_range(255)));
  endtask

  task automatic send_free_live();
    send_command(bia_pkg::CMD_FREE, sb.pick_live());
  endtask

  task automatic run_sequences(input int unsigned fill_cap);
    int unsigned n;
    full_hits = 0;
    n = 0;
    // Fill mostly with allocates until the store reports full three times or fill_cap commands are sent.
    while (full_hits < 3 && n < fill_cap) begin
      if ($urandom_range(99) < 5 && sb.live > 0) send_free_live();
      else send_alloc();
      n++;
    end
    repeat (60) begin
      if ($urandom_range(1)) send_alloc();
      else if ($urandom_range(99) < 80) send_free_live();
      else send_command(bia_pkg::CMD_FREE, 8'($urandom_range(255)));
    end
    // Drain to empty so the last free clears the store, with stray frees.
    while (sb.live != 0) begin
      if ($urandom_range(99) < 10) send_command(bia_pkg::CMD_FREE, 8'($urandom_range(255)));
      else send_free_live();
    end
  endtask

  always @(negedge clk_i) begin
    out_stall <= ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk_i) begin : response_monitor
    string faults[$];
    if (rst_ni && out_valid && !out_stall) begin
      sb.check_response(out_data, faults);
      foreach (faults[i]) report_mismatch(faults[i]);
    end
  end

  initial begin
    sb        = new();
    errors    = 0;
    full_hits = 0;
    send_idle = 24;
    recv_idle = 58;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    out_stall = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Frees against an empty store, then a few allocates from the mark.
    send_command(bia_pkg::CMD_FREE, 8'd0);
    send_command(bia_pkg::CMD_FREE, 8'd255);
    send_command(bia_pkg::CMD_ALLOC, 8'hff);
    send_command(bia_pkg::CMD_ALLOC, 8'h00);
    send_command(bia_pkg::CMD_ALLOC, 8'haa);
    send_command(bia_pkg::CMD_ALLOC, 8'h55);
    send_command(bia_pkg::CMD_ALLOC, 8'h0f);
    send_command(bia_pkg::CMD_ALLOC, 8'hf0);
    // Double free, free at the mark and far above it.
    send_command(bia_pkg::CMD_FREE, 8'd3);
    send_command(bia_pkg::CMD_FREE, 8'd3);
    send_command(bia_pkg::CMD_FREE, 8'd6);
    send_command(bia_pkg::CMD_FREE, 8'd200);
    send_command(bia_pkg::CMD_FREE, 8'd1);
    // Holes are reused before the mark moves again.
    send_command(bia_pkg::CMD_ALLOC, 8'd0);
    send_command(bia_pkg::CMD_ALLOC, 8'd0);
    send_command(bia_pkg::CMD_ALLOC, 8'd0);
    for (int i = 0; i <= 6; i++) send_command(bia_pkg::CMD_FREE, 8'(i));
    send_command(bia_pkg::CMD_ALLOC, 8'd0);
    send_command(bia_pkg::CMD_FREE, 8'd0);

    run_sequences(300);
    send_idle = 58;
    recv_idle = 24;
    run_sequences(40);
    send_idle = 0;
    recv_idle = 0;
    run_sequences(300);

    @(negedge clk_i);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
